[design/sut_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sut_pkg
// Shared constants, codes and types for the sorted unique table.
// ----------------------------------------------------------------------------
package sut_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_DUP    = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_COMPARE,
    S_UPDATE
  } state_t;

  // Broadcast control from the sequencer to every cell
  typedef struct packed {
    logic compare;
    logic insert;
    logic remove;
  } cell_ctrl_t;

endpackage

[design/sorted_unique_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_table
// The accepting edge moves to the compare state, where every cell registers
// its less and equal flags, then to the update state, which shifts the row
// on insert or remove and registers the result; done rises as update ends.
// A new command is accepted only in idle; busy is high in compare and update.
// Reset (rst, synchronous) empties the table; no clearing pass is needed.
// The receiver cannot stall: each result is shown for one cycle with done.
// ----------------------------------------------------------------------------
module sorted_unique_table
  import sut_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              cmd,
  input  logic signed [KEY_W-1:0] value,
  output logic                    done,
  output logic [1:0]              status,
  output logic                    found,
  output logic [CNT_W-1:0]        position,
  output logic [CNT_W-1:0]        entry_count
);

  state_t               state, state_next;
  logic [1:0]           cmd_q;
  logic signed [KEY_W-1:0] key;
  logic [CNT_W-1:0]     count_held, count_next;
  cell_ctrl_t           ctrl;
  status_t              status_calc;
  logic                 present;
  logic [CNT_W-1:0]     pos_calc;

  logic signed [KEY_W-1:0] entries [CAPACITY];
  logic [CAPACITY-1:0]  less_vec;
  logic [CAPACITY-1:0]  equal_vec;
  logic [CAPACITY-1:0]  left_less_vec;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic signed [KEY_W-1:0] left_e;
      logic signed [KEY_W-1:0] right_e;
      if (gi == 0) begin : g_first
        assign left_less_vec[gi] = 1'b1;
        assign left_e            = key;
      end else begin : g_mid
        assign left_less_vec[gi] = less_vec[gi-1];
        assign left_e            = entries[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_e = '0;
      end else begin : g_inner
        assign right_e = entries[gi+1];
      end

      sut_cell u_cell (
        .clk         (clk),
        .ctrl        (ctrl),
        .occupied    (CNT_W'(gi) < count_held),
        .key         (key),
        .left_less   (left_less_vec[gi]),
        .left_entry  (left_e),
        .right_entry (right_e),
        .entry       (entries[gi]),
        .less        (less_vec[gi]),
        .equal       (equal_vec[gi])
      );
    end
  endgenerate

  assign busy = (state != S_IDLE);

  // Insertion point: encode the thermometer edge of the less flags
  always_comb begin
    pos_calc = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!less_vec[i] && left_less_vec[i]) begin
        pos_calc = pos_calc | CNT_W'(i);
      end
    end
    if (less_vec[CAPACITY-1]) begin
      pos_calc = CNT_W'(CAPACITY);
    end
  end

  assign present = |equal_vec;

  always_comb begin
    state_next   = state;
    ctrl         = '0;
    count_next   = count_held;
    status_calc  = present ? ST_DONE : ST_ABSENT;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_COMPARE;
        end
      end
      S_COMPARE: begin
        ctrl.compare = 1'b1;
        state_next   = S_UPDATE;
      end
      S_UPDATE: begin
        state_next = S_IDLE;
        unique case (cmd_q)
          CMD_INSERT: begin
            if (present) begin
              status_calc = ST_DUP;
            end else if (count_held == CNT_W'(CAPACITY)) begin
              status_calc = ST_FULL;
            end else begin
              ctrl.insert = 1'b1;
              count_next  = count_held + CNT_W'(1);
              status_calc = ST_DONE;
            end
          end
          CMD_REMOVE: begin
            if (present) begin
              ctrl.remove = 1'b1;
              count_next  = count_held - CNT_W'(1);
            end
          end
          default: begin
            // search, and the unused code acts as search
          end
        endcase
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count_held <= '0;
      done       <= 1'b0;
    end else begin
      state      <= state_next;
      count_held <= count_next;
      done       <= (state == S_UPDATE);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd_q <= cmd;
      key   <= value;
    end
    if (state == S_UPDATE) begin
      status      <= status_calc;
      found       <= present;
      position    <= pos_calc;
      entry_count <= count_next;
    end
  end

endmodule

[design/sut_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sut_cell
// One slot of the table: holds a key, compares it against the broadcast key
// and shifts with its neighbors on insert or remove.
// ----------------------------------------------------------------------------
module sut_cell
  import sut_pkg::*;
(
  input  logic                    clk,
  input  cell_ctrl_t              ctrl,
  input  logic                    occupied,
  input  logic signed [KEY_W-1:0] key,
  input  logic                    left_less,
  input  logic signed [KEY_W-1:0] left_entry,
  input  logic signed [KEY_W-1:0] right_entry,
  output logic signed [KEY_W-1:0] entry,
  output logic                    less,
  output logic                    equal
);

  always_ff @(posedge clk) begin
    if (ctrl.compare) begin
      less  <= occupied && (entry < key);
      equal <= occupied && (entry == key);
    end
    // less is a thermometer over the row; left_less on a non-less cell
    // marks the insertion point
    if (ctrl.insert && !less) begin
      entry <= left_less ? key : left_entry;
    end else if (ctrl.remove && !less) begin
      entry <= right_entry;
    end
  end

endmodule

[test/sorted_unique_table_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_table_test
// Self-checking bench for the sorted unique table. A directed table covers
// the empty table, the key extremes, duplicates, misses and the unused
// command code. Random fill and drain sequences then push the table to full
// and back, under several sender idle rates. Each result is checked against
// its row's typed values or a behavioral copy of the table kept in a queue.
// ----------------------------------------------------------------------------
module sorted_unique_table_test;
  import sut_pkg::*;

  localparam int                      HALF_PERIOD = 4;
  localparam int                      RAND_ITEMS  = 830;
  localparam int                      CYCLE_LIMIT = 200000;
  localparam int                      DRAIN_WAIT  = 8;
  localparam logic [1:0]              CMD_UNUSED  = 2'd3;
  localparam logic signed [KEY_W-1:0] KEY_MIN     = {1'b1, {(KEY_W-1){1'b0}}};
  localparam logic signed [KEY_W-1:0] KEY_MAX     = ~KEY_MIN;

  typedef struct packed {
    logic [1:0]       st;
    logic             fnd;
    logic [CNT_W-1:0] pos;
    logic [CNT_W-1:0] cnt;
  } outcome_t;

  typedef struct {
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    bit                      typed;
    outcome_t                res;
  } dir_row_t;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [1:0]              cmd;
  logic signed [KEY_W-1:0] value;
  logic                    done;
  logic [1:0]              status;
  logic                    found;
  logic [CNT_W-1:0]        position;
  logic [CNT_W-1:0]        entry_count;

  logic signed [KEY_W-1:0] held_keys[$];
  outcome_t                pending_results[$];
  int                      errors      = 0;
  int                      cycle_count = 0;
  int                      idle_pct    = 0;

  // Rows with typed results are checked against those values; the rest
  // against the table model.
  dir_row_t dir_rows [25] = '{
    '{CMD_SEARCH, 0,             1, '{ST_ABSENT, 1'b0, 7'd0, 7'd0}},
    '{CMD_REMOVE, 5,             1, '{ST_ABSENT, 1'b0, 7'd0, 7'd0}},
    '{CMD_INSERT, KEY_MAX,       1, '{ST_DONE,   1'b0, 7'd0, 7'd1}},
    '{CMD_INSERT, KEY_MIN,       1, '{ST_DONE,   1'b0, 7'd0, 7'd2}},
    '{CMD_INSERT, KEY_MAX,       1, '{ST_DUP,    1'b1, 7'd1, 7'd2}},
    '{CMD_INSERT, KEY_MIN,       1, '{ST_DUP,    1'b1, 7'd0, 7'd2}},
    '{CMD_SEARCH, KEY_MAX,       1, '{ST_DONE,   1'b1, 7'd1, 7'd2}},
    '{CMD_INSERT, 0,             1, '{ST_DONE,   1'b0, 7'd1, 7'd3}},
    '{CMD_INSERT, -1,            0, '0},
    '{CMD_INSERT, 1,             0, '0},
    '{CMD_SEARCH, 2,             0, '0},
    '{CMD_UNUSED, 0,             0, '0},
    '{CMD_UNUSED, 5,             0, '0},
    '{CMD_REMOVE, 0,             0, '0},
    '{CMD_REMOVE, 0,             0, '0},
    '{CMD_REMOVE, KEY_MIN,       0, '0},
    '{CMD_REMOVE, KEY_MAX,       0, '0},
    '{CMD_SEARCH, KEY_MIN + 1,   0, '0},
    '{CMD_INSERT, 32'sh55555555, 0, '0},
    '{CMD_INSERT, 32'shAAAAAAAA, 0, '0},
    '{CMD_REMOVE, -1,            0, '0},
    '{CMD_REMOVE, 1,             0, '0},
    '{CMD_REMOVE, 32'sh55555555, 0, '0},
    '{CMD_REMOVE, 32'shAAAAAAAA, 0, '0},
    '{CMD_SEARCH, -1,            1, '{ST_ABSENT, 1'b0, 7'd0, 7'd0}}
  };

  sorted_unique_table dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .value       (value),
    .done        (done),
    .status      (status),
    .found       (found),
    .position    (position),
    .entry_count (entry_count)
  );

  initial clk = 1'b0;
  always #HALF_PERIOD clk = ~clk;

  // Apply one command to the model table and return its result.
  function automatic outcome_t table_apply(logic [1:0] op, logic signed [KEY_W-1:0] key);
    outcome_t o;
    int       slot;
    bit       hit;
    slot = 0;
    while (slot < held_keys.size() && held_keys[slot] < key) slot++;
    hit = (slot < held_keys.size()) && (held_keys[slot] == key);
    o.st = hit ? ST_DONE : ST_ABSENT;
    if (op == CMD_INSERT) begin
      if (hit) begin
        o.st = ST_DUP;
      end else if (held_keys.size() >= CAPACITY) begin
        o.st = ST_FULL;
      end else begin
        held_keys.insert(slot, key);
        o.st = ST_DONE;
      end
    end else if (op == CMD_REMOVE && hit) begin
      held_keys.delete(slot);
    end
    o.fnd = hit;
    o.pos = slot[CNT_W-1:0];
    o.cnt = CNT_W'(held_keys.size());
    return o;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_cmd(logic [1:0] op, logic signed [KEY_W-1:0] key, bit typed,
                          outcome_t typed_res);
    outcome_t pred;
    while ($urandom_range(99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    cmd   = op;
    value = key;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = table_apply(op, key);
    pending_results.push_back(typed ? typed_res : pred);
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          errors++;
        end
        if (found !== want.fnd) begin
          $error("found: expected %0d, got %0d", want.fnd, found);
          errors++;
        end
        if (position !== want.pos) begin
          $error("position: expected %0d, got %0d", want.pos, position);
          errors++;
        end
        if (entry_count !== want.cnt) begin
          $error("entry_count: expected %0d, got %0d", want.cnt, entry_count);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL sorted_unique_table");
      $finish;
    end
  end

  initial begin : stimulus
    bit                      filling;
    int                      sel;
    int                      reuse_pct;
    logic [1:0]              op;
    logic signed [KEY_W-1:0] key;
    rst     = 1'b1;
    start   = 1'b0;
    cmd     = CMD_INSERT;
    value   = '0;
    filling = 1'b1;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i])
      send_cmd(dir_rows[i].op, dir_rows[i].key, dir_rows[i].typed, dir_rows[i].res);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      case (n / 200)
        1:       idle_pct = 77;
        2:       idle_pct = 17;
        default: idle_pct = 0;
      endcase

      // Alternate fill and drain sequences: up to full, down to four or fewer
      if (filling && held_keys.size() == CAPACITY && $urandom_range(9) == 0)
        filling = 1'b0;
      else if (!filling && held_keys.size() <= $urandom_range(4))
        filling = 1'b1;

      sel = $urandom_range(99);
      if (filling)
        op = (sel < 70) ? CMD_INSERT : (sel < 82) ? CMD_REMOVE :
             (sel < 95) ? CMD_SEARCH : CMD_UNUSED;
      else
        op = (sel < 65) ? CMD_REMOVE : (sel < 77) ? CMD_INSERT :
             (sel < 95) ? CMD_SEARCH : CMD_UNUSED;

      reuse_pct = filling ? 20 : 60;
      sel = $urandom_range(99);
      if (sel < reuse_pct && held_keys.size() > 0)
        key = held_keys[$urandom_range(held_keys.size() - 1)];
      else if (sel < 75)
        key = $urandom;
      else if (sel < 90)
        key = $signed($urandom_range(16)) - 8;
      else begin
        case ($urandom_range(3))
          0:       key = KEY_MIN;
          1:       key = KEY_MAX;
          2:       key = KEY_MIN + 1;
          default: key = KEY_MAX - 1;
        endcase
      end

      send_cmd(op, key, 1'b0, '0);
    end

    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0)
      $display("PASS sorted_unique_table");
    else
      $display("FAIL sorted_unique_table");
    $finish;
  end

endmodule
